[design/wfr_pkg.sv]
// Shared types and constants of the Wiegand frame receiver.
package wfr_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned BIT_INDEX_W = 6;
  localparam int unsigned FRAME_LEN_W = 7;
  localparam int unsigned FUNC_W      = 2;

  localparam logic [TIME_W-1:0] IDLE_GAP_RESET = 32'd1600000;
  localparam logic [MASK_W-1:0] LEN_MASK_RESET = 64'h0001_013D_0500_0110;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_GAP = 1'b0,
    CFG_LEN_MASK = 1'b1
  } cfg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_D0   = 2'd0,
    FUNC_D1   = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_ARM  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic edge_wr;
    logic arm;
    logic tick_rd;
    logic idx_clr;
    logic idx_rd;
    logic idx_inc;
    logic cnt_clr;
    logic disarm;
  } wfr_cmd_t;

  typedef struct packed {
    logic armed;
    logic full;
    logic cnt_zero;
    logic gap_exceeded;
    logic len_ok;
    logic idx_last;
  } wfr_sts_t;

endpackage

[design/wiegand_frame_receiver_top.sv]
// Wiegand frame receiver: edge capture into bit stores, idle-gap frame end, bit readout.
// Edge and arm requests are taken in ST_IDLE and leave the block there; it is ready again in the next cycle.
// Idle check tick: store read of the last fall time, then the gap compare in ST_CHECK.
// Frame readout: per bit, a store read in ST_READ, then the bit is held valid in ST_EMIT until taken.
// Reset: bit count zero, armed, config registers at defaults; stores hold no reset.
module wiegand_frame_receiver_top #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wfr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [wfr_pkg::FUNC_W-1:0]        func_i,
  input  logic                              rising_i,
  input  logic [wfr_pkg::TIME_W-1:0]        now_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              bit_value_o,
  output logic [wfr_pkg::BIT_INDEX_W-1:0]   bit_index_o,
  output logic [wfr_pkg::TIME_W-1:0]        fall_time_o,
  output logic [wfr_pkg::TIME_W-1:0]        rise_time_o,
  output logic [wfr_pkg::FRAME_LEN_W-1:0]   frame_length_o,
  output logic                              last_o
);
  import wfr_pkg::*;

  wfr_cmd_t cmd;
  wfr_sts_t sts;

  wfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wfr_datapath #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .line_bit_i     (func_i[0]),
    .rising_i       (rising_i),
    .now_i          (now_i),
    .bit_value_o    (bit_value_o),
    .bit_index_o    (bit_index_o),
    .fall_time_o    (fall_time_o),
    .rise_time_o    (rise_time_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

endmodule

[design/wfr_ctrl.sv]
// Control state machine: request decode, idle check and frame readout sequencing.
module wfr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wfr_pkg::FUNC_W-1:0]    func_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  wfr_pkg::wfr_sts_t             sts_i,
  output wfr_pkg::wfr_cmd_t             cmd_o
);
  import wfr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_ARM: begin
              cmd_o.arm = 1'b1;
            end
            FUNC_D0, FUNC_D1: begin
              cmd_o.edge_wr = sts_i.armed && !sts_i.full;
            end
            FUNC_TICK: begin
              if (sts_i.armed && !sts_i.cnt_zero) begin
                cmd_o.tick_rd = 1'b1;
                state_d       = ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (sts_i.gap_exceeded) begin
          if (sts_i.len_ok) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_READ;
          end else begin
            cmd_o.cnt_clr = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.idx_rd = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.idx_last) begin
            cmd_o.disarm = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[design/wfr_datapath.sv]
// Datapath: config registers, bit and timestamp stores, counters and result registers.
module wfr_datapath #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wfr_pkg::wfr_cmd_t                 cmd_i,
  output wfr_pkg::wfr_sts_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [wfr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              line_bit_i,
  input  logic                              rising_i,
  input  logic [wfr_pkg::TIME_W-1:0]        now_i,
  output logic                              bit_value_o,
  output logic [wfr_pkg::BIT_INDEX_W-1:0]   bit_index_o,
  output logic [wfr_pkg::TIME_W-1:0]        fall_time_o,
  output logic [wfr_pkg::TIME_W-1:0]        rise_time_o,
  output logic [wfr_pkg::FRAME_LEN_W-1:0]   frame_length_o,
  output logic                              last_o
);
  import wfr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME_BITS);
  localparam int unsigned CW = $clog2(MAX_FRAME_BITS + 1);

  logic [TIME_W-1:0] idle_gap_q;
  logic [MASK_W-1:0] len_mask_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              armed_q, armed_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [TIME_W-1:0] now_q;

  logic              bit_mem  [MAX_FRAME_BITS];
  logic [TIME_W-1:0] fall_mem [MAX_FRAME_BITS];
  logic [TIME_W-1:0] rise_mem [MAX_FRAME_BITS];

  logic              bit_rd_q;
  logic [TIME_W-1:0] fall_rd_q;
  logic [TIME_W-1:0] rise_rd_q;

  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [CW-1:0]          cnt_m1;
  logic                   rd_en;
  logic [TIME_W-1:0]      elapsed;
  logic [FRAME_LEN_W-1:0] n7;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_gap_q <= IDLE_GAP_RESET;
      len_mask_q <= LEN_MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IDLE_GAP: idle_gap_q <= cfg_data_i[TIME_W-1:0];
        CFG_LEN_MASK: len_mask_q <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.arm || cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.edge_wr && rising_i) begin
      cnt_d = cnt_q + CW'(1);
    end
    armed_d = armed_q;
    if (cmd_i.arm) begin
      armed_d = 1'b1;
    end else if (cmd_i.disarm) begin
      armed_d = 1'b0;
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      armed_q <= 1'b1;
      idx_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_rd) begin
      now_q <= now_i;
    end
  end

  // Stores: write at the current bit position, one registered read port
  assign wr_addr = cnt_q[AW-1:0];
  assign cnt_m1  = cnt_q - CW'(1);
  assign rd_addr = cmd_i.tick_rd ? cnt_m1[AW-1:0] : idx_q;
  assign rd_en   = cmd_i.tick_rd || cmd_i.idx_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr) begin
      bit_mem[wr_addr] <= line_bit_i;
      if (rising_i) begin
        rise_mem[wr_addr] <= now_i;
      end else begin
        fall_mem[wr_addr] <= now_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bit_rd_q  <= bit_mem[rd_addr];
      fall_rd_q <= fall_mem[rd_addr];
      rise_rd_q <= rise_mem[rd_addr];
    end
  end

  // Status
  assign elapsed = now_q - fall_rd_q;
  assign n7      = FRAME_LEN_W'(cnt_q);

  always_comb begin
    sts_o.armed        = armed_q;
    sts_o.full         = (cnt_q >= CW'(MAX_FRAME_BITS));
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.gap_exceeded = (elapsed > idle_gap_q);
    sts_o.len_ok       = !n7[FRAME_LEN_W-1] && len_mask_q[n7[BIT_INDEX_W-1:0]];
    sts_o.idx_last     = ((CW'(idx_q) + CW'(1)) == cnt_q);
  end

  assign bit_value_o    = bit_rd_q;
  assign bit_index_o    = BIT_INDEX_W'(idx_q);
  assign fall_time_o    = fall_rd_q;
  assign rise_time_o    = rise_rd_q;
  assign frame_length_o = n7;
  assign last_o         = sts_o.idx_last;

endmodule

[design/wfr_checker.sv]
// Port-level checker for the Wiegand frame receiver, bound to the top level.
module wfr_sva (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              bit_value_o,
  input logic [wfr_pkg::BIT_INDEX_W-1:0]   bit_index_o,
  input logic [wfr_pkg::TIME_W-1:0]        fall_time_o,
  input logic [wfr_pkg::TIME_W-1:0]        rise_time_o,
  input logic [wfr_pkg::FRAME_LEN_W-1:0]   frame_length_o,
  input logic                              last_o
);

  // no request taken while a frame is being read out
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(bit_index_o) && $stable(fall_time_o) &&
       $stable(rise_time_o) && $stable(bit_value_o) && $stable(last_o)))
    else $error("stalled result changed");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> ##1
      (out_valid_o && bit_index_o == $past(bit_index_o, 2) + 6'd1))
    else $error("bit index did not advance by one");

  a_last_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> ({1'b0, bit_index_o} + 7'd1 == frame_length_o))
    else $error("last bit index does not match frame length");

endmodule

bind wiegand_frame_receiver_top wfr_sva u_wfr_checker (.*);

[tb/wfr_checker.sv]
// Checker for the Wiegand frame receiver: bit-store model, expected readout queue, compare.
`timescale 1ns / 100ps
module wfr_checker #(
  parameter int unsigned MAX_FRAME_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [wfr_pkg::FUNC_W-1:0]      func_i,
  input  logic                            rising_i,
  input  logic [wfr_pkg::TIME_W-1:0]      now_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            bit_value_i,
  input  logic [wfr_pkg::BIT_INDEX_W-1:0] bit_index_i,
  input  logic [wfr_pkg::TIME_W-1:0]      fall_time_i,
  input  logic [wfr_pkg::TIME_W-1:0]      rise_time_i,
  input  logic [wfr_pkg::FRAME_LEN_W-1:0] frame_length_i,
  input  logic                            last_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output logic [wfr_pkg::FRAME_LEN_W-1:0] rx_cnt_o,
  output logic                            armed_o,
  output logic [63:0]                     fall_written_o
);
  import wfr_pkg::*;

  typedef struct packed {
    logic                   bit_value;
    logic [BIT_INDEX_W-1:0] bit_index;
    logic [TIME_W-1:0]      fall_time;
    logic [TIME_W-1:0]      rise_time;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   last;
  } wfr_bit_t;

  logic [TIME_W-1:0]      idle_gap;
  logic [MASK_W-1:0]      len_mask;
  logic                   bit_mem [64];
  logic [TIME_W-1:0]      fall_mem [64];
  logic [TIME_W-1:0]      rise_mem [64];
  logic [FRAME_LEN_W-1:0] rx_cnt;
  logic                   armed;
  logic [63:0]            fall_written;
  wfr_bit_t               expected_bits [$];
  wfr_bit_t               exp_bit;

  task automatic decode_event(input logic [FUNC_W-1:0] f, input logic r,
                              input logic [TIME_W-1:0] t);
    logic [FRAME_LEN_W-1:0] n;
    logic [TIME_W-1:0]      elapsed;
    logic                   len_ok;
    wfr_bit_t               item;
    if (f == FUNC_ARM) begin
      rx_cnt = '0;
      armed  = 1'b1;
    end else if (armed) begin
      if (f == FUNC_TICK) begin
        n = rx_cnt;
        if (n != '0) begin
          elapsed = t - fall_mem[n - 7'd1];
          if (elapsed > idle_gap) begin
            len_ok = (n < MASK_W) ? len_mask[n[5:0]] : 1'b0;
            if (len_ok) begin
              for (int i = 0; i < n; i++) begin
                item.bit_value    = bit_mem[i];
                item.bit_index    = i[BIT_INDEX_W-1:0];
                item.fall_time    = fall_mem[i];
                item.rise_time    = rise_mem[i];
                item.frame_length = n;
                item.last         = (i + 1 == n);
                expected_bits.push_back(item);
              end
              armed = 1'b0;
            end else begin
              rx_cnt = '0;
            end
          end
        end
      end else if (rx_cnt < MAX_FRAME_BITS) begin
        bit_mem[rx_cnt[5:0]] = f[0];
        if (r) begin
          rise_mem[rx_cnt[5:0]] = t;
          rx_cnt = rx_cnt + 7'd1;
        end else begin
          fall_mem[rx_cnt[5:0]]     = t;
          fall_written[rx_cnt[5:0]] = 1'b1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_gap     = IDLE_GAP_RESET;
      len_mask     = LEN_MASK_RESET;
      rx_cnt       = '0;
      armed        = 1'b1;
      fall_written = '0;
      fail_count_o = 0;
      expected_bits.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDLE_GAP) begin
          idle_gap = cfg_data_i[TIME_W-1:0];
        end else begin
          len_mask = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_event(func_i, rising_i, now_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_bits.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0d",
                   $time, bit_index_i);
          fail_count_o++;
        end else begin
          exp_bit = expected_bits.pop_front();
          check_field("bit_value", 32'(exp_bit.bit_value), 32'(bit_value_i));
          check_field("bit_index", 32'(exp_bit.bit_index), 32'(bit_index_i));
          check_field("fall_time", exp_bit.fall_time, fall_time_i);
          check_field("rise_time", exp_bit.rise_time, rise_time_i);
          check_field("frame_length", 32'(exp_bit.frame_length), 32'(frame_length_i));
          check_field("last", 32'(exp_bit.last), 32'(last_i));
        end
      end
    end
    pending_o      = expected_bits.size();
    rx_cnt_o       = rx_cnt;
    armed_o        = armed;
    fall_written_o = fall_written;
  end

endmodule

[tb/wiegand_frame_receiver_top_tb.sv]
// Testbench top for the Wiegand frame receiver: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module wiegand_frame_receiver_top_tb;
  import wfr_pkg::*;

  localparam int unsigned STORE_BITS     = 64;
  localparam int unsigned N_PHASES       = 6;
  localparam int unsigned PHASE_ITEMS    = 25;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned FLUSH_CYCLES   = 2 * STORE_BITS + 12;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [FUNC_W-1:0]      func_i;
  logic                   rising_i;
  logic [TIME_W-1:0]      now_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   bit_value_o;
  logic [BIT_INDEX_W-1:0] bit_index_o;
  logic [TIME_W-1:0]      fall_time_o;
  logic [TIME_W-1:0]      rise_time_o;
  logic [FRAME_LEN_W-1:0] frame_length_o;
  logic                   last_o;

  int unsigned            fail_count;
  int unsigned            pending;
  logic [FRAME_LEN_W-1:0] rx_cnt;
  logic                   armed;
  logic [63:0]            fall_written;

  int unsigned            in_idle_pct   = 0;
  int unsigned            out_stall_pct = 0;
  int unsigned            hold_req      = 0;
  int unsigned            hold_done     = 0;
  int unsigned            items_sent    = 0;
  int unsigned            idle_cycles   = 0;
  int unsigned            phase_end;
  int unsigned            choice;
  logic [TIME_W-1:0]      clk_now;
  logic [TIME_W-1:0]      last_fall;
  logic [TIME_W-1:0]      idle_gap = IDLE_GAP_RESET;
  logic [MASK_W-1:0]      len_mask = LEN_MASK_RESET;

  always #2 clk_i = ~clk_i;

  wiegand_frame_receiver_top #(
    .MAX_FRAME_BITS(STORE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .rising_i      (rising_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bit_value_o   (bit_value_o),
    .bit_index_o   (bit_index_o),
    .fall_time_o   (fall_time_o),
    .rise_time_o   (rise_time_o),
    .frame_length_o(frame_length_o),
    .last_o        (last_o)
  );

  wfr_checker #(
    .MAX_FRAME_BITS(STORE_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .func_i        (func_i),
    .rising_i      (rising_i),
    .now_i         (now_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bit_value_i   (bit_value_o),
    .bit_index_i   (bit_index_o),
    .fall_time_i   (fall_time_o),
    .rise_time_i   (rise_time_o),
    .frame_length_i(frame_length_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .rx_cnt_o      (rx_cnt),
    .armed_o       (armed),
    .fall_written_o(fall_written)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver side: random stalls, plus a long hold on request from the stimulus
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = hold_req;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  task automatic send_req(input logic [FUNC_W-1:0] f, input logic r,
                          input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    rising_i   <= r;
    now_i      <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [TIME_W-1:0] gap, input logic [MASK_W-1:0] mask);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDLE_GAP;
    cfg_data_i <= {$urandom, gap};
    @(negedge clk_i);
    cfg_idx_i  <= CFG_LEN_MASK;
    cfg_data_i <= mask;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
    idle_gap = gap;
    len_mask = mask;
  endtask

  // fall then rise per bit; optional early tick inside the gap, then an optional ending tick
  task automatic send_frame(input int unsigned nbits, input bit early_tick,
                            input bit end_tick, input bit hold);
    logic line;
    if (!armed || rx_cnt != 0) send_req(FUNC_ARM, 1'($urandom_range(1)), clk_now);
    for (int unsigned b = 0; b < nbits; b++) begin
      line = 1'($urandom_range(1));
      clk_now += $urandom_range(200, 1);
      last_fall = clk_now;
      send_req(line ? FUNC_D1 : FUNC_D0, 1'b0, clk_now);
      if ($urandom_range(15) == 0) line = ~line;
      clk_now += $urandom_range(200, 1);
      send_req(line ? FUNC_D1 : FUNC_D0, 1'b1, clk_now);
    end
    if (early_tick) begin
      send_req(FUNC_TICK, 1'($urandom_range(1)), last_fall + $urandom_range(idle_gap, 0));
    end
    if (end_tick) begin
      if (hold) hold_req++;
      clk_now = last_fall + idle_gap + 1 + $urandom_range(1000);
      send_req(FUNC_TICK, 1'($urandom_range(1)), clk_now);
    end
  endtask

  // a rise the receiver would take is only sent at a position whose fall time has been stored
  task automatic send_noise();
    logic [FUNC_W-1:0] f;
    logic              r;
    logic [TIME_W-1:0] t;
    f = FUNC_W'($urandom_range(3));
    r = 1'($urandom_range(1));
    t = ($urandom_range(1) == 1) ? $urandom : last_fall + $urandom_range(3000);
    if (r && (f == FUNC_D0 || f == FUNC_D1) && armed && rx_cnt < STORE_BITS &&
        !fall_written[rx_cnt[5:0]]) begin
      r = 1'b0;
    end
    send_req(f, r, t);
  endtask

  function automatic int unsigned pick_length();
    int unsigned n;
    if ($urandom_range(3) == 0) return $urandom_range(12, 1);
    repeat (24) begin
      n = ($urandom_range(1) == 1) ? $urandom_range(12, 1) : $urandom_range(40, 1);
      if (len_mask[n]) return n;
    end
    return $urandom_range(12, 1);
  endfunction

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IDLE_GAP;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    func_i     = FUNC_ARM;
    rising_i   = 1'b0;
    now_i      = '0;
    clk_now    = 32'hFFFF_FFFF - 32'd1_000_000;
    last_fall  = clk_now;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_req(FUNC_TICK, 1'b1, 32'hFFFF_FFFF);
    send_req(FUNC_ARM, 1'b1, '0);
    send_frame(4, 1'b1, 1'b1, 1'b0);
    // disarmed after readout: edges and ticks are dropped
    send_req(FUNC_D1, 1'b0, '0);
    send_req(FUNC_D1, 1'b1, '1);
    send_req(FUNC_TICK, 1'b0, clk_now + idle_gap + 2);
    send_req(FUNC_ARM, 1'b0, clk_now);
    send_frame(3, 1'b0, 1'b1, 1'b0);
    send_req(FUNC_TICK, 1'b0, clk_now + 5);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drain();
      case (p)
        1:       set_config('0, '1);
        2:       set_config('1, {$urandom, $urandom});
        3:       set_config($urandom_range(100000, 1), '0);
        4:       set_config($urandom_range(5000, 1), {$urandom, $urandom} | 64'h0FF0);
        5:       set_config(IDLE_GAP_RESET, LEN_MASK_RESET);
        default: ;
      endcase
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 67; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 23; out_stall_pct = 23; end
      endcase
      if (p != 0) clk_now = $urandom;
      phase_end = items_sent + PHASE_ITEMS;
      if (p == 0) send_frame(8, 1'b0, 1'b1, 1'b1);
      if (p == 1) send_frame(STORE_BITS + 2, 1'b0, 1'b1, 1'b0);
      while (items_sent < phase_end) begin
        choice = $urandom_range(9);
        if (choice < 6) begin
          send_frame(pick_length(), $urandom_range(2) == 0, 1'b1, 1'b0);
        end else if (choice < 7) begin
          send_frame(pick_length(), 1'b0, 1'b0, 1'b0);
        end else begin
          repeat ($urandom_range(4, 1)) send_noise();
        end
        if ($urandom_range(5) == 0) wait_drain();
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (FLUSH_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
